/* sv/mbes_pkg.sv */
// Shared types and constants for the mask boundary edge scan.
// No dependencies; imported by the block, the checker and the testbench top.
package mbes_pkg;

    // Coordinate and size register width, and endpoint width (x+1 may carry).
    localparam int COORD_W = 13;
    localparam int BOX_W   = COORD_W + 1;

    // Size used for the height clamp and the size registers after reset.
    localparam int MAX_HEIGHT = 4096;
    localparam logic [COORD_W-1:0] RESET_SIZE = 13'd256;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERT  = 2'd0,
        KIND_HORIZ = 2'd1,
        KIND_BOX   = 2'd2
    } t_item_kind;

endpackage

/* sv/mbes_line_store.sv */
// Line store: one bit per column, synchronous read-first RAM, one address.
// Standalone; used by mask_boundary_edge_scan.
module mbes_line_store #(
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_wr_bit,
    output logic              o_rd_bit
);

    logic r_mem [DEPTH];
    logic r_rd_bit;

    // Read returns the old content when the same entry is written.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_bit;
        end
        if (i_rd_en) begin
            r_rd_bit <= r_mem[i_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;

endmodule

/* sv/mask_boundary_edge_scan.sv */
// Mask boundary edge scan: crack edges and bounding box of a binary mask.
// Each result word passes through the stage 1 register and then the single output register.
// Throughput: one input word per cycle while the output is not stalled and each yields
// at most one result; a word with more holds the input until its last result is taken.
// Reset: synchronous, active low; sizes return to 256 x 256, the line store is not cleared.
// Depends on mbes_pkg and mbes_line_store.
module mask_boundary_edge_scan #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_pixel_set,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_item_kind,
    output logic [12:0] o_edge_x,
    output logic [12:0] o_edge_y,
    output logic [12:0] o_box_min_x,
    output logic [12:0] o_box_min_y,
    output logic [12:0] o_box_max_x,
    output logic [12:0] o_box_max_y,
    output logic        o_box_empty,
    output logic        o_last_of_run,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbes_pkg::*;

    localparam int LINE_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // ------------------------------------------------------------------
    // Configuration registers. A write restarts the frame.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_width, r_height;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_SIZE;
            r_height <= RESET_SIZE;
        end else if (cfg_we) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[COORD_W-1:0];
            end else begin
                r_height <= pwdata[COORD_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HEIGHT) begin
            prdata[COORD_W-1:0] = r_height;
        end else begin
            prdata[COORD_W-1:0] = r_width;
        end
    end

    // Effective sizes: zero reads as one, above the maximum reads as the maximum.
    logic [COORD_W-1:0] w_eff, h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = COORD_W'(1);
        end else if (17'(r_width) > 17'(MAX_WIDTH)) begin
            w_eff = COORD_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = COORD_W'(1);
        end else if (17'(r_height) > 17'(MAX_HEIGHT)) begin
            h_eff = COORD_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: scan position, left pixel, line store access.
    // The store entry for column x is read (old row) and written (this row)
    // in the same cycle; its next access is a full row later, so no
    // forwarding is needed.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_col, r_row;
    logic               r_left;
    logic               in_accept;
    logic               x_pad, y_pad, in_frame, pix_value, pix_left, top_ok, frame_end;
    logic               line_rd_bit;

    assign in_accept = i_in_valid && !o_in_stall;
    assign x_pad     = (r_col >= w_eff);
    assign y_pad     = (r_row >= h_eff);
    assign in_frame  = !x_pad && !y_pad;
    assign pix_value = in_frame && i_pixel_set;
    assign pix_left  = (r_col == '0 || y_pad) ? 1'b0 : r_left;
    assign top_ok    = (r_row != '0) && !x_pad;
    assign frame_end = x_pad && y_pad;

    mbes_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_rd_en  (in_accept),
        .i_wr_en  (in_accept && in_frame),
        .i_addr   (LINE_AW'(r_col)),
        .i_wr_bit (pix_value),
        .o_rd_bit (line_rd_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= 1'b0;
        end else if (in_accept) begin
            if (frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_left <= 1'b0;
            end else if (x_pad) begin
                r_col  <= '0;
                r_row  <= r_row + COORD_W'(1);
                r_left <= pix_value;
            end else begin
                r_col  <= r_col + COORD_W'(1);
                r_left <= pix_value;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: compare with the pixel above, hand out up to three words
    // (vertical, horizontal, box) one per cycle into the output register while it is free.
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    logic [COORD_W-1:0] r_s1_x, r_s1_y;
    logic               r_s1_value, r_s1_left, r_s1_top_ok, r_s1_end;
    logic               r_s1_sent_v, r_s1_sent_h;

    logic               pix_top, need_v, need_h, need_any;
    logic               out_free, emit, emit_last, s1_adv;
    t_item_kind         emit_kind;

    assign pix_top  = r_s1_top_ok && line_rd_bit;
    assign need_v   = (r_s1_left != r_s1_value) && !r_s1_sent_v;
    assign need_h   = (pix_top != r_s1_value) && !r_s1_sent_h;
    assign need_any = need_v || need_h || r_s1_end;

    logic r_out_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = r_s1_valid && need_any && out_free;

    always_comb begin
        priority if (need_v) begin
            emit_kind = KIND_VERT;
            emit_last = !need_h && !r_s1_end;
        end else if (need_h) begin
            emit_kind = KIND_HORIZ;
            emit_last = !r_s1_end;
        end else begin
            emit_kind = KIND_BOX;
            emit_last = 1'b1;
        end
    end

    assign s1_adv     = r_s1_valid && (!need_any || (emit && emit_last));
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_x      <= r_col;
            r_s1_y      <= r_row;
            r_s1_value  <= pix_value;
            r_s1_left   <= pix_left;
            r_s1_top_ok <= top_ok;
            r_s1_end    <= frame_end;
            r_s1_sent_v <= 1'b0;
            r_s1_sent_h <= 1'b0;
        end else if (emit) begin
            if (emit_kind == KIND_VERT) begin
                r_s1_sent_v <= 1'b1;
            end
            if (emit_kind == KIND_HORIZ) begin
                r_s1_sent_h <= 1'b1;
            end
        end
    end

    // Bounding box over edge endpoints; one bit wider since x+1 / y+1 may carry.
    logic [BOX_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic             r_any_edge;
    logic [BOX_W-1:0] ep_x0, ep_y0, ep_x1, ep_y1;
    logic             emit_edge, emit_box;

    assign emit_edge = emit && (emit_kind != KIND_BOX);
    assign emit_box  = emit && (emit_kind == KIND_BOX);
    assign ep_x0     = {1'b0, r_s1_x};
    assign ep_y0     = {1'b0, r_s1_y};
    assign ep_x1     = (emit_kind == KIND_HORIZ) ? ep_x0 + BOX_W'(1) : ep_x0;
    assign ep_y1     = (emit_kind == KIND_VERT) ? ep_y0 + BOX_W'(1) : ep_y0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || emit_box) begin
            r_any_edge <= 1'b0;
            r_min_x    <= '0;
            r_min_y    <= '0;
            r_max_x    <= '0;
            r_max_y    <= '0;
        end else if (emit_edge) begin
            r_any_edge <= 1'b1;
            if (!r_any_edge) begin
                r_min_x <= ep_x0;
                r_min_y <= ep_y0;
                r_max_x <= ep_x1;
                r_max_y <= ep_y1;
            end else begin
                if (ep_x0 < r_min_x) r_min_x <= ep_x0;
                if (ep_y0 < r_min_y) r_min_y <= ep_y0;
                if (ep_x1 > r_max_x) r_max_x <= ep_x1;
                if (ep_y1 > r_max_y) r_max_y <= ep_y1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    t_item_kind         r_out_kind;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [COORD_W-1:0] r_out_min_x, r_out_min_y, r_out_max_x, r_out_max_y;
    logic               r_out_empty, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_last <= emit_last;
            if (emit_box) begin
                // box word: edge coordinates zero, box zero when empty
                r_out_x     <= '0;
                r_out_y     <= '0;
                r_out_min_x <= r_any_edge ? r_min_x[COORD_W-1:0] : '0;
                r_out_min_y <= r_any_edge ? r_min_y[COORD_W-1:0] : '0;
                r_out_max_x <= r_any_edge ? r_max_x[COORD_W-1:0] : '0;
                r_out_max_y <= r_any_edge ? r_max_y[COORD_W-1:0] : '0;
                r_out_empty <= !r_any_edge;
            end else begin
                r_out_x     <= r_s1_x;
                r_out_y     <= r_s1_y;
                r_out_min_x <= '0;
                r_out_min_y <= '0;
                r_out_max_x <= '0;
                r_out_max_y <= '0;
                r_out_empty <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item_kind   = r_out_kind;
    assign o_edge_x      = r_out_x;
    assign o_edge_y      = r_out_y;
    assign o_box_min_x   = r_out_min_x;
    assign o_box_min_y   = r_out_min_y;
    assign o_box_max_x   = r_out_max_x;
    assign o_box_max_y   = r_out_max_y;
    assign o_box_empty   = r_out_empty;
    assign o_last_of_run = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with stage 1 empty");

    a_box_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_BOX) |-> r_out_last)
        else $error("box word not marked last");

    a_empty_only_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_kind == KIND_BOX))
        else $error("empty flag on an edge word");

    a_box_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_box |=> !r_any_edge)
        else $error("box not cleared after report");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_col <= w_eff))
        else $error("column counter past padding column");

endmodule

/* tb/mbes_checker.sv */
// Scoreboard for the mask boundary edge scan: predicts edge and box words from
// accepted pixels and APB writes, compares the result channel, checks readback.
// Depends on mbes_pkg.
module mbes_checker #(
    parameter int LINE_MAX = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_pixel_set,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_item_kind,
    input  logic [12:0] i_edge_x,
    input  logic [12:0] i_edge_y,
    input  logic [12:0] i_box_min_x,
    input  logic [12:0] i_box_min_y,
    input  logic [12:0] i_box_max_x,
    input  logic [12:0] i_box_max_y,
    input  logic        i_box_empty,
    input  logic        i_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbes_pkg::*;

    typedef struct {
        t_item_kind  kind;
        logic [12:0] edge_x;
        logic [12:0] edge_y;
        logic [12:0] min_x;
        logic [12:0] min_y;
        logic [12:0] max_x;
        logic [12:0] max_y;
        logic        empty;
        logic        last;
    } t_edge_word;

    t_edge_word  expected_words[$];
    bit          line_store[LINE_MAX];
    logic [12:0] width_reg  = RESET_SIZE;
    logic [12:0] height_reg = RESET_SIZE;
    int          col_pos, row_pos;
    int          box_x0, box_y0, box_x1, box_y1;
    bit          left_bit, edge_found;
    int          mismatches;

    function automatic int usable_size(logic [12:0] v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic void restart_scan();
        left_bit   = 0;
        col_pos    = 0;
        row_pos    = 0;
        box_x0     = 0;
        box_y0     = 0;
        box_x1     = 0;
        box_y1     = 0;
        edge_found = 0;
    endfunction

    function automatic void grow_box(int x0, int y0, int x1, int y1);
        if (!edge_found) begin
            box_x0 = x0;
            box_y0 = y0;
            box_x1 = x1;
            box_y1 = y1;
            edge_found = 1;
        end else begin
            if (x0 < box_x0) box_x0 = x0;
            if (y0 < box_y0) box_y0 = y0;
            if (x1 > box_x1) box_x1 = x1;
            if (y1 > box_y1) box_y1 = y1;
        end
    endfunction

    function automatic t_edge_word blank_word(t_item_kind kind);
        t_edge_word w;
        w.kind   = kind;
        w.edge_x = '0;
        w.edge_y = '0;
        w.min_x  = '0;
        w.min_y  = '0;
        w.max_x  = '0;
        w.max_y  = '0;
        w.empty  = 1'b0;
        w.last   = 1'b0;
        return w;
    endfunction

    // One raster position: up to a vertical edge, a horizontal edge and the box.
    function automatic void scan_pixel(bit pix);
        t_edge_word run[$];
        t_edge_word w;
        int  fw, fh, x, y;
        bit  in_mask, value, left, top;
        fw = usable_size(width_reg, LINE_MAX);
        fh = usable_size(height_reg, MAX_HEIGHT);
        x = col_pos;
        y = row_pos;
        in_mask = (x < fw) && (y < fh);
        value   = in_mask ? pix : 1'b0;
        left    = (x == 0 || y >= fh) ? 1'b0 : left_bit;
        top     = (y == 0 || x >= fw) ? 1'b0 : line_store[x];
        if (left != value) begin
            w = blank_word(KIND_VERT);
            w.edge_x = x[12:0];
            w.edge_y = y[12:0];
            run.insert(run.size(), w);
            grow_box(x, y, x, y + 1);
        end
        if (top != value) begin
            w = blank_word(KIND_HORIZ);
            w.edge_x = x[12:0];
            w.edge_y = y[12:0];
            run.insert(run.size(), w);
            grow_box(x, y, x + 1, y);
        end
        if (in_mask) line_store[x] = value;
        left_bit = value;
        if (x >= fw && y >= fh) begin
            w = blank_word(KIND_BOX);
            if (edge_found) begin
                w.min_x = box_x0[12:0];
                w.min_y = box_y0[12:0];
                w.max_x = box_x1[12:0];
                w.max_y = box_y1[12:0];
            end else begin
                w.empty = 1'b1;
            end
            run.insert(run.size(), w);
            restart_scan();
        end else if (x >= fw) begin
            col_pos = 0;
            row_pos = y + 1;
        end else begin
            col_pos = x + 1;
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_words.insert(expected_words.size(), run[i]);
    endfunction

    function automatic string word_text(logic [1:0] kind, logic [12:0] ex, logic [12:0] ey,
                                        logic [12:0] x0, logic [12:0] y0, logic [12:0] x1,
                                        logic [12:0] y1, logic empty, logic last);
        return $sformatf("kind=%0d at (%0d,%0d) box (%0d,%0d)-(%0d,%0d) empty=%0b last=%0b",
                         kind, ex, ey, x0, y0, x1, y1, empty, last);
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function automatic void check_word();
        t_edge_word exp;
        string      got;
        got = word_text(i_item_kind, i_edge_x, i_edge_y, i_box_min_x, i_box_min_y,
                        i_box_max_x, i_box_max_y, i_box_empty, i_last_of_run);
        if (expected_words.size() == 0) begin
            note_failure({"unexpected result word: ", got});
            return;
        end
        exp = expected_words.pop_front();
        if (i_item_kind !== exp.kind || i_edge_x !== exp.edge_x || i_edge_y !== exp.edge_y ||
            i_box_min_x !== exp.min_x || i_box_min_y !== exp.min_y ||
            i_box_max_x !== exp.max_x || i_box_max_y !== exp.max_y ||
            i_box_empty !== exp.empty || i_last_of_run !== exp.last)
            note_failure({"result word mismatch: expected ",
                          word_text(exp.kind, exp.edge_x, exp.edge_y, exp.min_x, exp.min_y,
                                    exp.max_x, exp.max_y, exp.empty, exp.last),
                          ", got ", got});
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RESET_SIZE;
            height_reg = RESET_SIZE;
            restart_scan();
            expected_words.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_WIDTH) width_reg = pwdata[12:0];
                    else height_reg = pwdata[12:0];
                    restart_scan();
                end else if (prdata !== {19'b0, (paddr[2] == REG_WIDTH) ? width_reg
                                                                        : height_reg}) begin
                    note_failure($sformatf("readback at 0x%0h: expected %0d, got 0x%0h", paddr,
                                 (paddr[2] == REG_WIDTH) ? width_reg : height_reg, prdata));
                end
            end
            if (i_out_valid && !i_out_stall) check_word();
            if (i_in_valid && !i_in_stall) scan_pixel(i_pixel_set);
        end
        o_pending    <= expected_words.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/tb_top.sv */
// Top of the mask boundary edge scan testbench: clock, reset, APB setup,
// pixel stimulus and output stall; checking lives in mbes_checker.
// Depends on mbes_pkg, mbes_checker and the block itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbes_pkg::*;

    localparam int LINE_MAX = 4096;

    // Which size registers a reconfiguration touches.
    typedef enum int {
        WRITE_BOTH,
        WRITE_WIDTH,
        WRITE_HEIGHT
    } t_size_write;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_pixel_set = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_item_kind;
    logic [12:0] o_edge_x, o_edge_y;
    logic [12:0] o_box_min_x, o_box_min_y, o_box_max_x, o_box_max_y;
    logic        o_box_empty, o_last_of_run;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_words;

    // Idling knobs: percent chance of a sender gap before a word / of a receiver stall burst.
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_hold = 0;
    bit quiet      = 1'b0;

    // Effective frame size as the block sees it, for laying out the stimulus.
    int cur_w = 256;
    int cur_h = 256;
    int words_sent = 0;

    // Pixel shape for the frame in progress: a filled rectangle or random noise.
    bit use_rect;
    int density;
    int rx0, rx1, ry0, ry1;

    mask_boundary_edge_scan #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_set  (i_pixel_set),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_item_kind  (o_item_kind),
        .o_edge_x     (o_edge_x),
        .o_edge_y     (o_edge_y),
        .o_box_min_x  (o_box_min_x),
        .o_box_min_y  (o_box_min_y),
        .o_box_max_x  (o_box_max_x),
        .o_box_max_y  (o_box_max_y),
        .o_box_empty  (o_box_empty),
        .o_last_of_run(o_last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    mbes_checker #(
        .LINE_MAX(LINE_MAX)
    ) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_pixel_set  (i_pixel_set),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_item_kind  (o_item_kind),
        .i_edge_x     (o_edge_x),
        .i_edge_y     (o_edge_y),
        .i_box_min_x  (o_box_min_x),
        .i_box_min_y  (o_box_min_y),
        .i_box_max_x  (o_box_max_x),
        .i_box_max_y  (o_box_max_y),
        .i_box_empty  (o_box_empty),
        .i_last_of_run(o_last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: random stall bursts, off entirely once quiet.
    always @(posedge i_clk) begin
        if (quiet || stall_pct == 0) begin
            i_out_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_hold  <= $urandom_range(7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Generous bound: every word with a full gap and three fully stalled results,
    // taken several times over.
    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Size register value as the block applies it: zero reads as one, big values clamp.
    function automatic int frame_dim(logic [12:0] v, int hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : int'(v));
    endfunction

    // All tasks below start and end just after a rising edge.

    // APB transfer: setup, access until pready, then idle before returning.
    // Upper data bits are junk on writes, since the registers keep only 13 bits.
    task automatic apb_access(bit write_op, logic reg_idx, logic [12:0] value);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_op;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {junk[31:13], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted word is out, then give the
    // stage 1 and output registers room for a word that produced nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_size(logic [12:0] w_raw, logic [12:0] h_raw, t_size_write which);
        drain();
        if (which != WRITE_HEIGHT) begin
            apb_access(1'b1, REG_WIDTH, w_raw);
            cur_w = frame_dim(w_raw, LINE_MAX);
        end
        if (which != WRITE_WIDTH) begin
            apb_access(1'b1, REG_HEIGHT, h_raw);
            cur_h = frame_dim(h_raw, MAX_HEIGHT);
        end
        apb_access(1'b0, REG_WIDTH, '0);
        apb_access(1'b0, REG_HEIGHT, '0);
    endtask

    // One pixel word, optionally preceded by a sender gap.
    task automatic send_pixel(bit pix);
        if (!quiet && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pixel_set <= pix;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic choose_shape();
        use_rect = 1'($urandom_range(1));
        case ($urandom_range(4))
            0: density = 0;
            1: density = 100;
            2: density = 50;
            3: density = 15;
            default: density = 85;
        endcase
        rx0 = $urandom_range(cur_w - 1);
        rx1 = $urandom_range(cur_w - 1, rx0);
        ry0 = $urandom_range(cur_h - 1);
        ry1 = $urandom_range(cur_h - 1, ry0);
    endtask

    function automatic bit pick_pixel(int x, int y);
        if (use_rect) return (x >= rx0 && x <= rx1 && y >= ry0 && y <= ry1);
        return ($urandom_range(99) < density);
    endfunction

    // Raster scan from (0,0); stops after word_limit words to cut a frame short.
    // Padding positions get a random bit, which the block must ignore.
    task automatic send_frame(int word_limit);
        int n;
        n = 0;
        for (int y = 0; y <= cur_h; y++) begin
            for (int x = 0; x <= cur_w; x++) begin
                if (n == word_limit) return;
                if (x < cur_w && y < cur_h) send_pixel(pick_pixel(x, y));
                else send_pixel(1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    function automatic logic [12:0] random_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 75) return 13'($urandom_range(1, 6));
        return 13'($urandom_range(7, 10));
    endfunction

    initial begin
        int rand_start;
        int frame_words;
        t_size_write which;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed, no idling ----
        // Zero sizes act as 1x1: a single set pixel gives a vertical and a
        // horizontal edge at the origin, the padding column and row close it.
        // Padding words carry 1s, which must be ignored.
        set_size(13'd0, 13'd0, WRITE_BOTH);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        // Blank frame: box report flagged empty.
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        // 2x2 checkerboard: every interior compare flips.
        set_size(13'd2, 13'd2, WRITE_BOTH);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        // Solid 3x1 strip: edges only on the border.
        set_size(13'd3, 13'd1, WRITE_BOTH);
        repeat (8) send_pixel(1'b1);

        // ---- largest sizes, light idling ----
        // Exact maximum, all-ones values that clamp, and zeros or ones on the other axis.
        // Only the start of each frame is sent; the next write restarts the scan.
        gap_pct   = 5;
        stall_pct = 5;
        set_size(13'd4096, 13'd0, WRITE_BOTH);
        choose_shape();
        send_frame(16);
        set_size(13'h1FFF, 13'd1, WRITE_BOTH);
        choose_shape();
        send_frame(16);
        set_size(13'd0, 13'h1FFF, WRITE_BOTH);
        choose_shape();
        send_frame(16);
        set_size(13'd1, 13'd4096, WRITE_BOTH);
        choose_shape();
        send_frame(16);

        // ---- random phases of small frames ----
        // Mostly complete frames with shaped content; now and then a frame is cut
        // short so the next register write has to restart the scan mid-frame.
        rand_start = words_sent;
        while (words_sent - rand_start < 160) begin
            if (words_sent - rand_start >= 120) quiet = 1'b1;
            gap_pct   = $urandom_range(3) * 20;
            stall_pct = $urandom_range(3) * 20;
            case ($urandom_range(5))
                0: which = WRITE_WIDTH;
                1: which = WRITE_HEIGHT;
                default: which = WRITE_BOTH;
            endcase
            set_size(random_dim(), random_dim(), which);
            frame_words = (cur_w + 1) * (cur_h + 1);
            repeat ($urandom_range(1, 3)) begin
                choose_shape();
                send_frame(frame_words);
            end
            if ($urandom_range(3) == 0) begin
                choose_shape();
                send_frame($urandom_range(1, frame_words - 1));
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/mbes_pkg.sv
sv/mbes_line_store.sv
sv/mask_boundary_edge_scan.sv
tb/mbes_checker.sv
tb/tb_top.sv
